@@ rtl/brfr_pkg.sv @@
// Shared constants, types and helper functions for the bitmap fill and rotate unit.
`timescale 1ns / 1ps

package brfr_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 64;

  localparam int OP_W     = 2;
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 4;
  localparam int INDEX_W  = 6;
  localparam int AMOUNT_W = 6;
  localparam int COUNT_W  = 10;

  localparam int ROW_CNT_W = $clog2(COLS + 1);
  localparam int SUM_W     = $clog2(ROWS * COLS + 1);
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int AMOUNT_N  = 1 << AMOUNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_FILL    = 2'd0,
    OP_ROT_ROW = 2'd1,
    OP_ROT_COL = 2'd2
  } op_t;

  typedef logic [COLS-1:0] row_t;
  typedef logic [ROWS-1:0][COLS-1:0] screen_t;
  typedef logic [ROW_CNT_W-1:0] row_cnt_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [INDEX_W-1:0]  index;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef logic [AMOUNT_W-1:0] mod_tab_t [AMOUNT_N];

  // Builds a table of every shift amount reduced modulo n.
  function automatic mod_tab_t make_mod_tab(input int n);
    mod_tab_t tab;
    int r;
    r = 0;
    for (int i = 0; i < AMOUNT_N; i++) begin
      tab[i] = AMOUNT_W'(r);
      r = r + 1;
      if (r == n) begin
        r = 0;
      end
    end
    return tab;
  endfunction

  localparam mod_tab_t COL_MOD = make_mod_tab(COLS);
  localparam mod_tab_t ROW_MOD = make_mod_tab(ROWS);

  function automatic row_cnt_t count_row(input row_t v);
    row_cnt_t total;
    total = '0;
    for (int j = 0; j < COLS; j++) begin
      total = total + row_cnt_t'(v[j]);
    end
    return total;
  endfunction

endpackage

@@ rtl/brfr_screen.sv @@
// Pixel screen register with the fill, row rotate and column rotate update logic.
`timescale 1ns / 1ps

module brfr_screen (
  input  logic             clk,
  input  logic             rst,
  input  logic             apply,
  input  brfr_pkg::cmd_t   cmd,
  output logic             bad,
  output brfr_pkg::screen_t screen
);
  import brfr_pkg::*;

  screen_t             screen_next;
  row_t                fill_mask;
  row_t                row_sel;
  row_t                row_rot;
  logic [2*COLS-1:0]   row_dbl;
  logic [ROWS-1:0]     col_sel;
  logic [ROWS-1:0]     col_rot;
  logic [2*ROWS-1:0]   col_dbl;
  logic [AMOUNT_W-1:0] row_dist;
  logic [AMOUNT_W-1:0] col_dist;

  always_comb begin
    row_dist  = COL_MOD[cmd.amount];
    col_dist  = ROW_MOD[cmd.amount];
    fill_mask = row_t'({COLS{1'b1}} >> (COLS - int'(cmd.width)));
    row_sel   = '0;
    col_sel   = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (cmd.index == INDEX_W'(i)) begin
        row_sel = screen[i];
      end
      for (int j = 0; j < COLS; j++) begin
        if (cmd.index == INDEX_W'(j)) begin
          col_sel[i] = screen[i][j];
        end
      end
    end
    row_dbl = {row_sel, row_sel};
    row_rot = row_t'(row_dbl >> (COLS - int'(row_dist)));
    col_dbl = {col_sel, col_sel};
    col_rot = ROWS'(col_dbl >> (ROWS - int'(col_dist)));
  end

  always_comb begin
    screen_next = screen;
    bad         = 1'b0;
    unique case (cmd.op)
      OP_FILL: begin
        if (int'(cmd.width) > COLS || int'(cmd.height) > ROWS) begin
          bad = 1'b1;
        end else begin
          for (int i = 0; i < ROWS; i++) begin
            if (int'(cmd.height) > i) begin
              screen_next[i] = screen[i] | fill_mask;
            end
          end
        end
      end
      OP_ROT_ROW: begin
        if (int'(cmd.index) >= ROWS) begin
          bad = 1'b1;
        end else begin
          for (int i = 0; i < ROWS; i++) begin
            if (cmd.index == INDEX_W'(i)) begin
              screen_next[i] = row_rot;
            end
          end
        end
      end
      OP_ROT_COL: begin
        if (int'(cmd.index) >= COLS) begin
          bad = 1'b1;
        end else begin
          for (int i = 0; i < ROWS; i++) begin
            for (int j = 0; j < COLS; j++) begin
              if (cmd.index == INDEX_W'(j)) begin
                screen_next[i][j] = col_rot[i];
              end
            end
          end
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen <= '0;
    end else if (apply) begin
      screen <= screen_next;
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !apply |=> $stable(screen))
    else $error("screen changed without an applied command");

  a_bad_holds: assert property (@(posedge clk) disable iff (rst)
    apply && bad |=> $stable(screen))
    else $error("rejected command changed the screen");

  a_fill_no_clear: assert property (@(posedge clk) disable iff (rst)
    apply && cmd.op == OP_FILL |=> ((screen & $past(screen)) == $past(screen)))
    else $error("fill turned a pixel off");

endmodule

@@ rtl/bitmap_rect_fill_and_rotate_unit.sv @@
// Top level of the bitmap fill and rotate unit: handshakes, count pipeline and result register.
`timescale 1ns / 1ps

// Channel   Signals                                                   Direction
// in        in_valid, in_ready, operation, rect_width, rect_height,   command in
//           line_index, shift_amount
// out       out_valid, out_ready, lit_count, bad_argument             result out
//
// One command word is taken per cycle while in_ready is high; its result word passes through p0, s1 and out.
// The screen is updated at the edge that accepts the command; per-row pixel counts
// are then registered and summed into the result register.
// Reset clears the screen and empties the pipeline.
// A stall on the output backs up through the count stages before in_ready falls.

module bitmap_rect_fill_and_rotate_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [brfr_pkg::OP_W-1:0]       operation,
  input  logic [brfr_pkg::WIDTH_W-1:0]    rect_width,
  input  logic [brfr_pkg::HEIGHT_W-1:0]   rect_height,
  input  logic [brfr_pkg::INDEX_W-1:0]    line_index,
  input  logic [brfr_pkg::AMOUNT_W-1:0]   shift_amount,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [brfr_pkg::COUNT_W-1:0]    lit_count,
  output logic                            bad_argument
);
  import brfr_pkg::*;

  cmd_t             cmd;
  logic             accept;
  logic             cmd_bad;
  screen_t          screen;
  logic             p0_valid;
  logic             p0_bad;
  logic             s1_valid;
  logic             s1_bad;
  row_cnt_t         row_cnt [ROWS];
  logic             out_load;
  logic             s1_adv;
  logic             p0_adv;
  logic [SUM_W-1:0] sum;

  assign cmd = '{op: operation, width: rect_width, height: rect_height,
                 index: line_index, amount: shift_amount};

  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign p0_adv   = p0_valid && (!s1_valid || s1_adv);
  assign in_ready = !p0_valid || p0_adv;
  assign accept   = in_valid && in_ready;

  brfr_screen u_screen (
    .clk    (clk),
    .rst    (rst),
    .apply  (accept),
    .cmd    (cmd),
    .bad    (cmd_bad),
    .screen (screen)
  );

  always_comb begin
    sum = '0;
    for (int i = 0; i < ROWS; i++) begin
      sum = sum + SUM_W'(row_cnt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        p0_valid <= 1'b1;
      end else if (p0_adv) begin
        p0_valid <= 1'b0;
      end
      if (p0_adv) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0_bad <= cmd_bad;
    end
    if (p0_adv) begin
      s1_bad <= p0_bad;
      for (int i = 0; i < ROWS; i++) begin
        row_cnt[i] <= count_row(screen[i]);
      end
    end
    if (s1_adv) begin
      bad_argument <= s1_bad;
      if (int'(sum) > COUNT_MAX) begin
        lit_count <= COUNT_W'(COUNT_MAX);
      end else begin
        lit_count <= COUNT_W'(sum);
      end
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> p0_valid)
    else $error("accepted command did not enter the pipeline");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    p0_valid && s1_valid && !s1_adv |-> !in_ready)
    else $error("input taken while the count stage is stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(lit_count) <= ROWS * COLS)
    else $error("lit count beyond screen size");

endmodule
